/* src/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/uelc_pkg.sv */
package uelc_pkg;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] TERM_RESET = 8'd35;

    localparam logic [3:0] GREET_LEN = 4'd6;
    localparam logic [3:0] ERR_LEN   = 4'd10;

    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_ECHO    = 2'd1;
    localparam logic [1:0] MODE_COLLECT = 2'd2;

    localparam logic [1:0] SRC_GREET = 2'd0;
    localparam logic [1:0] SRC_LINE  = 2'd1;
    localparam logic [1:0] SRC_ERR   = 2'd2;

    // "Ciao" CR LF
    function automatic logic [7:0] greet_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h43;
            4'd1:    b = 8'h69;
            4'd2:    b = 8'h61;
            4'd3:    b = 8'h6f;
            4'd4:    b = CH_CR;
            4'd5:    b = CH_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // CR LF "Errore" CR LF
    function automatic logic [7:0] err_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = CH_CR;
            4'd1:    b = CH_LF;
            4'd2:    b = 8'h45;
            4'd3:    b = 8'h72;
            4'd4:    b = 8'h72;
            4'd5:    b = 8'h6f;
            4'd6:    b = 8'h72;
            4'd7:    b = 8'h65;
            4'd8:    b = CH_CR;
            4'd9:    b = CH_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/uart_echo_line_collector.sv */
// the result of an accepted event appears in the output register in the next cycle
// throughput: one event per cycle while in_stall is low; the line buffer read issued at accept lands
// in its read data register together with the output register
// reset: greeting mode, terminator '#', output empty; no clearing pass, the
// buffer holds only payload bytes and the CR LF framing comes from logic
module uart_echo_line_collector #(
    parameter int MAX_LINE = 10
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic [1:0] mode,
    output logic       rx_enabled
);

    localparam int BUF_DEPTH = MAX_LINE + 4;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int PW_RAW    = $clog2(MAX_LINE + 5);
    localparam int PW        = (PW_RAW > 4) ? PW_RAW : 4;
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LINE + 3);

    logic [7:0]    term_reg;
    logic [1:0]    mode_reg,  mode_next;
    logic [PW-1:0] pos_reg,   pos_next;
    logic [1:0]    src_reg,   src_next;
    logic [PW-1:0] len_reg,   len_next;
    logic          busy_reg,  busy_next;

    logic          out_valid_reg;
    logic          out_txv_reg, out_txv_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_mem_reg, out_mem_next;
    logic [1:0]    out_mode_reg;

    logic [7:0]    line_mem [BUF_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] rd_addr;

    logic          accept;
    logic [PW-1:0] pos_inc;
    logic          is_term;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign pos_inc   = pos_reg + PW'(1);
    assign is_term   = (rx_byte == term_reg);
    assign rd_addr   = pos_inc[AW-1:0];

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        src_next      = src_reg;
        len_next      = len_reg;
        busy_next     = busy_reg;
        out_txv_next  = 1'b0;
        out_byte_next = 8'h00;
        out_mem_next  = 1'b0;
        wr_en         = 1'b0;

        if (!action) begin
            busy_next = 1'b0;
            if (mode_reg != uelc_pkg::MODE_ECHO && mode_reg != uelc_pkg::MODE_COLLECT)
            begin
                if (pos_inc < len_reg) begin
                    pos_next     = pos_inc;
                    out_txv_next = 1'b1;
                    case (src_reg)
                        uelc_pkg::SRC_GREET:
                        begin
                            out_byte_next = uelc_pkg::greet_byte(pos_inc[3:0]);
                        end
                        uelc_pkg::SRC_LINE:
                        begin
                            // framing bytes at both ends, payload from the buffer
                            if (pos_inc >= PW'(2) && pos_inc < len_reg - PW'(2)) begin
                                out_mem_next = 1'b1;
                            end else if (pos_inc == len_reg - PW'(2) || pos_inc == '0) begin
                                out_byte_next = uelc_pkg::CH_CR;
                            end else begin
                                out_byte_next = uelc_pkg::CH_LF;
                            end
                        end
                        default:
                        begin
                            out_byte_next = uelc_pkg::err_byte(pos_inc[3:0]);
                        end
                    endcase
                end else begin
                    mode_next = uelc_pkg::MODE_ECHO;
                    pos_next  = '0;
                end
            end
        end else begin
            case (mode_reg)
                uelc_pkg::MODE_ECHO:
                begin
                    if (is_term) begin
                        pos_next  = PW'(2);
                        mode_next = uelc_pkg::MODE_COLLECT;
                    end else if (!busy_reg) begin
                        busy_next     = 1'b1;
                        out_txv_next  = 1'b1;
                        out_byte_next = rx_byte;
                    end
                end
                uelc_pkg::MODE_COLLECT:
                begin
                    if (pos_reg < POS_LIMIT) begin
                        if (is_term) begin
                            // terminator becomes CR LF, both supplied when sending
                            len_next      = pos_reg + PW'(2);
                            src_next      = uelc_pkg::SRC_LINE;
                            pos_next      = '0;
                            mode_next     = uelc_pkg::MODE_SEND;
                            out_txv_next  = 1'b1;
                            out_byte_next = uelc_pkg::CH_CR;
                        end else begin
                            wr_en    = 1'b1;
                            pos_next = pos_inc;
                        end
                    end else begin
                        pos_next      = '0;
                        mode_next     = uelc_pkg::MODE_SEND;
                        src_next      = uelc_pkg::SRC_ERR;
                        len_next      = PW'(uelc_pkg::ERR_LEN);
                        out_txv_next  = 1'b1;
                        out_byte_next = uelc_pkg::CH_CR;
                    end
                end
                default:
                begin
                    // receiver off while sending
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            term_reg      <= uelc_pkg::TERM_RESET;
            mode_reg      <= uelc_pkg::MODE_SEND;
            pos_reg       <= '0;
            src_reg       <= uelc_pkg::SRC_GREET;
            len_reg       <= PW'(uelc_pkg::GREET_LEN);
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                term_reg <= cfg_data;
            end
            if (accept) begin
                mode_reg      <= mode_next;
                pos_reg       <= pos_next;
                src_reg       <= src_next;
                len_reg       <= len_next;
                busy_reg      <= busy_next;
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // writes happen only in collect mode, at pos_reg, and the read at accept takes the entry after it,
    // so one entry is never written and read at the same edge
    always_ff @(posedge clk)
    begin
        if (accept && wr_en) begin
            line_mem[pos_reg[AW-1:0]] <= rx_byte;
        end
        if (accept) begin
            rd_data_reg  <= line_mem[rd_addr];
            out_txv_reg  <= out_txv_next;
            out_byte_reg <= out_byte_next;
            out_mem_reg  <= out_mem_next;
            out_mode_reg <= mode_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = out_txv_reg;
    assign tx_byte    = out_mem_reg ? rd_data_reg : out_byte_reg;
    assign mode       = out_mode_reg;
    assign rx_enabled = (out_mode_reg == uelc_pkg::MODE_ECHO) ||
                        (out_mode_reg == uelc_pkg::MODE_COLLECT);

endmodule

/* src/uelc_checker.sv */
`include "assert_macros.svh"

module uelc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic [1:0] mode
);

    logic held;
    logic mode_known;
    logic was_collect_reg;
    logic left_collect;

    assign held         = out_valid && out_stall;
    assign mode_known   = (mode == uelc_pkg::MODE_SEND) || (mode == uelc_pkg::MODE_ECHO) ||
                          (mode == uelc_pkg::MODE_COLLECT);
    assign left_collect = was_collect_reg && out_valid && (mode == uelc_pkg::MODE_SEND);

    // result shown on the previous edge was in collect mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_collect_reg <= 1'b0;
        end
        else
        begin
            was_collect_reg <= out_valid && (mode == uelc_pkg::MODE_COLLECT);
        end
    end

    // input side only backs up when a result is waiting
    `ASSERT_IMPL(a_stall_needs_result, in_stall, held, "stall without held result")

    // an idle transmit slot carries a zero byte
    `ASSERT_IMPL(a_idle_byte_zero, out_valid && !tx_valid, tx_byte == 8'h00, "nonzero idle byte")

    // mode of a shown result is always a defined code
    `ASSERT_IMPL(a_mode_code, out_valid, mode_known, "undefined mode code")

    // a held result keeps its byte
    `ASSERT_NEXT(a_hold_byte, held, out_valid && $stable(tx_byte), "held result changed")

    // leaving collect mode always launches a byte, either the line or the error text
    `ASSERT_IMPL(a_exit_sends, left_collect, tx_valid, "collect exit without transfer")

endmodule

bind uart_echo_line_collector uelc_checker u_uelc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .mode      (mode)
);
